/* rtl/bidirectional_lis_length_unit_defines.svh */
// Assertion macros shared by the longest monotone run unit
`ifndef BIDIRECTIONAL_LIS_LENGTH_UNIT_DEFINES_SVH
`define BIDIRECTIONAL_LIS_LENGTH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BLIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blis check failed");

// Next-cycle implication, checked outside reset
`define BLIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blis check failed");

`endif

/* rtl/blis_pkg.sv */
// Shared types for the longest monotone run unit
`timescale 1ns / 1ps
package blis_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;   // latch item, open both searches
    logic rd;      // read both tables at the probe midpoints
    logic cmp;     // narrow both search windows
    logic wr;      // write tails, bump lengths
    logic finish;  // load result, clear sequence
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_full;
    logic search_done;
    logic last;
    logic out_full;
  } dp_status_t;

endpackage

/* rtl/blis_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module blis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/blis_ctrl.sv */
// Controller: sequences accept, binary search probes, table write and result
`timescale 1ns / 1ps
module blis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  blis_pkg::dp_status_t status_i,
  output blis_pkg::dp_cmd_t    cmd_o
);

  blis_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      blis_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // a full sequence skips the tables entirely
          state_d = status_i.count_full ? blis_pkg::ST_FINISH : blis_pkg::ST_PROBE;
        end
      end
      blis_pkg::ST_PROBE: begin
        if (status_i.search_done) begin
          cmd_o.wr = 1'b1;
          state_d  = status_i.last ? blis_pkg::ST_FINISH : blis_pkg::ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = blis_pkg::ST_CMP;
        end
      end
      blis_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = blis_pkg::ST_PROBE;
      end
      blis_pkg::ST_FINISH: begin
        if (!status_i.last) begin
          state_d = blis_pkg::ST_IDLE;
        end else if (!status_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = blis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/blis_dp.sv */
// Datapath: tails tables, search windows, lengths, counters, result register
`timescale 1ns / 1ps
module blis_dp #(
  parameter int MAX_LEN     = 128,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  blis_pkg::dp_cmd_t    cmd_i,
  output blis_pkg::dp_status_t status_o,
  input  logic [15:0]          height_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           longest_length_o,
  output logic                 overflow_o
);

  localparam int TW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic [TW-1:0] h_q;
  logic          last_q, last_d;
  logic [LW-1:0] rise_len_q, rise_len_d, fall_len_q, fall_len_d;
  logic [LW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] r_lo_q, r_lo_d, r_hi_q, r_hi_d;
  logic [LW-1:0] f_lo_q, f_lo_d, f_hi_q, f_hi_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_len_q;
  logic          out_ovf_q;

  logic [LW:0]   r_sum, f_sum;
  logic [LW-1:0] r_mid, f_mid, best;
  logic          r_busy, f_busy;
  logic [TW-1:0] r_rd_data, f_rd_data;

  // Probe midpoints
  assign r_sum  = {1'b0, r_lo_q} + {1'b0, r_hi_q};
  assign f_sum  = {1'b0, f_lo_q} + {1'b0, f_hi_q};
  assign r_mid  = r_sum[LW:1];
  assign f_mid  = f_sum[LW:1];
  assign r_busy = r_lo_q < r_hi_q;
  assign f_busy = f_lo_q < f_hi_q;

  // Tails tables; a replaced tail equal to the item rewrites the same value
  blis_ram #(.WIDTH(TW), .DEPTH(MAX_LEN)) u_rise_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr),
    .wr_addr_i (r_lo_q[AW-1:0]),
    .wr_data_i (h_q),
    .rd_en_i   (cmd_i.rd & r_busy),
    .rd_addr_i (r_mid[AW-1:0]),
    .rd_data_o (r_rd_data)
  );

  blis_ram #(.WIDTH(TW), .DEPTH(MAX_LEN)) u_fall_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr),
    .wr_addr_i (f_lo_q[AW-1:0]),
    .wr_data_i (h_q),
    .rd_en_i   (cmd_i.rd & f_busy),
    .rd_addr_i (f_mid[AW-1:0]),
    .rd_data_o (f_rd_data)
  );

  // Sequence state and search windows
  always_comb begin
    last_d     = last_q;
    rise_len_d = rise_len_q;
    fall_len_d = fall_len_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    r_lo_d     = r_lo_q;
    r_hi_d     = r_hi_q;
    f_lo_d     = f_lo_q;
    f_hi_d     = f_hi_q;
    if (cmd_i.start) begin
      last_d = last_i;
      r_lo_d = '0;
      r_hi_d = rise_len_q;
      f_lo_d = '0;
      f_hi_d = fall_len_q;
      if (status_o.count_full) begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.cmp) begin
      // rising: tail below item moves past it; falling: tail above item
      if (r_busy) begin
        if (r_rd_data < h_q) begin
          r_lo_d = r_mid + LW'(1);
        end else begin
          r_hi_d = r_mid;
        end
      end
      if (f_busy) begin
        if (f_rd_data > h_q) begin
          f_lo_d = f_mid + LW'(1);
        end else begin
          f_hi_d = f_mid;
        end
      end
    end
    if (cmd_i.wr) begin
      count_d = count_q + LW'(1);
      if (r_lo_q == rise_len_q) begin
        rise_len_d = rise_len_q + LW'(1);
      end
      if (f_lo_q == fall_len_q) begin
        fall_len_d = fall_len_q + LW'(1);
      end
    end
    if (cmd_i.finish) begin
      rise_len_d = '0;
      fall_len_d = '0;
      count_d    = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      rise_len_q  <= '0;
      fall_len_q  <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      r_lo_q      <= '0;
      r_hi_q      <= '0;
      f_lo_q      <= '0;
      f_hi_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      rise_len_q  <= rise_len_d;
      fall_len_q  <= fall_len_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      r_lo_q      <= r_lo_d;
      r_hi_q      <= r_hi_d;
      f_lo_q      <= f_lo_d;
      f_hi_q      <= f_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result: larger length, saturated to the output width
  assign best = (rise_len_q > fall_len_q) ? rise_len_q : fall_len_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      h_q <= height_i[TW-1:0];
    end
    if (cmd_i.finish) begin
      out_len_q <= (32'(best) > 32'd255) ? 8'hFF : 8'(best);
      out_ovf_q <= ovf_q;
    end
  end

  assign status_o.count_full  = (count_q == LW'(MAX_LEN));
  assign status_o.search_done = !r_busy && !f_busy;
  assign status_o.last        = last_q;
  assign status_o.out_full    = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;
  assign overflow_o       = out_ovf_q;

endmodule

/* rtl/bidirectional_lis_length_unit.sv */
// Longest strictly monotone subsequence unit: top level
// An item is accepted in the idle state, then runs its binary search probes and a
// table write; an item marked last also passes through the finish state. The number
// of probes S is ceil(log2(L+1)) for the longer of the two tails tables of length L.
// A search only runs while fewer than MAX_LEN items have been taken, so L stays
// below MAX_LEN. Each probe is a table read and then a compare, because the table
// RAMs have a registered read and the next probe address depends on the compare of
// the last. Both tables search in step. Items beyond MAX_LEN in a sequence skip the
// tables and only flag overflow. A last item waits in the finish state while the
// previous result is still untaken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "bidirectional_lis_length_unit_defines.svh"
module bidirectional_lis_length_unit #(
  parameter int MAX_LEN     = 128,
  parameter int HEIGHT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] height_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  longest_length_o,
  output logic        overflow_o
);

  localparam int LEN_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;

  blis_pkg::dp_cmd_t    cmd;
  blis_pkg::dp_status_t status;

  // Sequencer
  blis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tables and result path
  blis_dp #(
    .MAX_LEN     (MAX_LEN),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .height_i         (height_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .longest_length_o (longest_length_o),
    .overflow_o       (overflow_o)
  );

  // Checks
  `BLIS_ASSERT_NOW(a_cmd_excl, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `BLIS_ASSERT_NEXT(a_rd_then_cmp, clk_i, rst_ni, cmd.rd, cmd.cmp)
  `BLIS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `BLIS_ASSERT_NOW(a_len_bound, clk_i, rst_ni, out_valid_o, 32'(longest_length_o) <= LEN_CAP)

endmodule
